/* rtl/core/lavm_pkg.sv */
// shared constants and beat types of the look-at view matrix core
package lavm_pkg;

	localparam int FRAC_BITS = 16;
	// quotient bits of one normalized component, at most 1.0
	localparam int QW = FRAC_BITS + 1;
	// signed unit-vector component
	localparam int UW = FRAC_BITS + 2;
	localparam int JW = $clog2(QW);
	// product of a unit component and a 32-bit operand
	localparam int PW = UW + 32;
	// dividend width of the normalizing divide
	localparam int NW = FRAC_BITS + 31;
	localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

	typedef logic signed [UW-1:0] uvec_t;
	typedef logic signed [63:0] wide_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] elem0;
		logic signed [31:0] elem1;
		logic signed [31:0] elem2;
		logic signed [31:0] elem3;
		logic               last_row;
		logic               degenerate;
	} out_beat_t;

	// classified item between front and back
	typedef struct packed {
		logic [2:0][31:0] cam;
		logic [2:0][32:0] d;
		logic [2:0][31:0] up;
		logic             degenerate;
	} fq_t;

endpackage

/* rtl/core/lavm_front.sv */
// front end: accepts camera beats, forms the view difference and queues them
module lavm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  lavm_pkg::in_beat_t   camera,
	output logic                 q_empty,
	output lavm_pkg::fq_t        q_data,
	input  logic                 q_pop
);

	lavm_pkg::fq_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	lavm_pkg::fq_t entry;
	logic          wr;
	logic          rd;

	always_comb begin
		entry.cam[0] = camera.cam_x;
		entry.cam[1] = camera.cam_y;
		entry.cam[2] = camera.cam_z;
		entry.up[0]  = camera.up_x;
		entry.up[1]  = camera.up_y;
		entry.up[2]  = camera.up_z;
		entry.d[0]   = {camera.target_x[31], camera.target_x} - {camera.cam_x[31], camera.cam_x};
		entry.d[1]   = {camera.target_y[31], camera.target_y} - {camera.cam_y[31], camera.cam_y};
		entry.d[2]   = {camera.target_z[31], camera.target_z} - {camera.cam_z[31], camera.cam_z};
		entry.degenerate = (entry.d[0] == '0) && (entry.d[1] == '0) && (entry.d[2] == '0);
	end

	assign full    = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign q_data  = slot_q[rp_q];
	assign wr      = push && !full;
	assign rd      = q_pop && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wp_q] <= entry;
	end

endmodule

/* rtl/core/lavm_norm.sv */
// vector normalizer: scale, sum of squares, bit-serial sqrt, serial divide
module lavm_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lavm_pkg::wide_t   v [3],
	output logic              done,
	output lavm_pkg::uvec_t   o [3]
);

	typedef enum logic [8:0] {
		N_IDLE  = 9'b000000001,
		N_MAX   = 9'b000000010,
		N_SCALE = 9'b000000100,
		N_SQ    = 9'b000001000,
		N_SQRT  = 9'b000010000,
		N_DIVI  = 9'b000100000,
		N_DIV   = 9'b001000000,
		N_DIVE  = 9'b010000000,
		N_DONE  = 9'b100000000
	} nstate_t;

	nstate_t                 state_q;
	logic [63:0]             a_q [3];
	logic [2:0]              neg_q;
	logic [63:0]             m_q;
	logic [1:0]              k_q;
	logic [1:0]              idx_q;
	logic [lavm_pkg::JW-1:0] j_q;
	logic [59:0]             sq_s1;
	logic                    sqv_s1;
	logic [63:0]             x_q;
	logic [63:0]             res_q;
	logic [63:0]             bit_q;
	logic [lavm_pkg::NW-1:0] rem_q;
	logic [lavm_pkg::QW-1:0] q_q;
	lavm_pkg::uvec_t         o_q [3];

	logic [63:0]             a01;
	logic [63:0]             mmax;
	logic                    in_range;
	logic [1:0]              ksel;
	logic [63:0]             rt_sum;
	logic [lavm_pkg::NW-1:0] dsub;

	always_comb begin
		a01      = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
		mmax     = (a01 > a_q[2]) ? a01 : a_q[2];
		in_range = (m_q >= (64'(1) << 29)) && (m_q < (64'(1) << 30));
		ksel     = (k_q == 2'd3) ? 2'd0 : k_q;
		rt_sum   = res_q + bit_q;
		dsub     = lavm_pkg::NW'(res_q[30:0]) << j_q;
	end

	assign done = (state_q == N_DONE);
	assign o    = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			k_q     <= 2'd0;
			idx_q   <= 2'd0;
			j_q     <= '0;
			sqv_s1  <= 1'b0;
		end else begin
			sqv_s1 <= (state_q == N_SQ) && (k_q != 2'd3);
			case (state_q)
				N_IDLE: begin
					idx_q <= 2'd0;
					if (start)
						state_q <= N_MAX;
				end
				N_MAX: begin
					state_q <= (mmax == 64'd0) ? N_DONE : N_SCALE;
				end
				N_SCALE: begin
					k_q <= 2'd0;
					if (in_range)
						state_q <= N_SQ;
				end
				N_SQ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3)
						state_q <= N_SQRT;
				end
				N_SQRT: begin
					if (bit_q[0])
						state_q <= N_DIVI;
				end
				N_DIVI: begin
					j_q     <= lavm_pkg::JW'(lavm_pkg::QW - 1);
					state_q <= N_DIV;
				end
				N_DIV: begin
					j_q <= j_q - 1'b1;
					if (j_q == '0)
						state_q <= N_DIVE;
				end
				N_DIVE: begin
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd2) ? N_DONE : N_DIVI;
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= a_q[ksel][29:0] * a_q[ksel][29:0];
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= v[i][63];
						a_q[i]   <= v[i][63] ? 64'(-v[i]) : 64'(v[i]);
					end
				end
			end
			N_MAX: begin
				m_q <= mmax;
				for (int i = 0; i < 3; i++)
					o_q[i] <= '0;
			end
			N_SCALE: begin
				// coarse steps first; a left shift never takes the largest to 2^30 or above
				if (m_q >= (64'(1) << 46)) begin
					m_q <= m_q >> 16;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] >> 16;
				end else if (m_q >= (64'(1) << 34)) begin
					m_q <= m_q >> 4;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] >> 4;
				end else if (m_q >= (64'(1) << 30)) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] >> 1;
				end else if (m_q < (64'(1) << 13)) begin
					m_q <= m_q << 16;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] << 16;
				end else if (m_q < (64'(1) << 25)) begin
					m_q <= m_q << 4;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] << 4;
				end else if (m_q < (64'(1) << 29)) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] << 1;
				end
				x_q   <= 64'd0;
				res_q <= 64'd0;
				bit_q <= 64'(1) << 62;
			end
			N_SQ: begin
				if (sqv_s1)
					x_q <= x_q + 64'(sq_s1);
			end
			N_SQRT: begin
				if (x_q >= rt_sum) begin
					x_q   <= x_q - rt_sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVI: begin
				rem_q <= (lavm_pkg::NW'(a_q[idx_q][29:0]) << lavm_pkg::FRAC_BITS)
					+ lavm_pkg::NW'(res_q[30:1]);
				q_q   <= '0;
			end
			N_DIV: begin
				if (rem_q >= dsub) begin
					rem_q    <= rem_q - dsub;
					q_q[j_q] <= 1'b1;
				end
			end
			N_DIVE: begin
				o_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/lavm_back.sv */
// back end: sequencer with shared multiplier, cross and dot products, row queue
module lavm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  lavm_pkg::fq_t        q_data,
	output logic                 q_pop,
	output logic                 norm_start,
	output lavm_pkg::wide_t      norm_v [3],
	input  logic                 norm_done,
	input  lavm_pkg::uvec_t      norm_o [3],
	output logic                 empty,
	input  logic                 pop,
	output lavm_pkg::out_beat_t  row
);

	typedef enum logic [9:0] {
		B_IDLE   = 10'b0000000001,
		B_NORM_F = 10'b0000000010,
		B_CROSS  = 10'b0000000100,
		B_CHK    = 10'b0000001000,
		B_NORM_R = 10'b0000010000,
		B_NORM_U = 10'b0000100000,
		B_DOT    = 10'b0001000000,
		B_ROW    = 10'b0010000000,
		B_LAST   = 10'b0100000000,
		B_ID     = 10'b1000000000
	} bstate_t;

	bstate_t                    state_q;
	logic signed [31:0]         cam_q [3];
	logic signed [31:0]         up_q [3];
	lavm_pkg::uvec_t            f_q [3];
	lavm_pkg::uvec_t            r_q [3];
	lavm_pkg::uvec_t            u_q [3];
	lavm_pkg::wide_t            c_q [3];
	lavm_pkg::wide_t            nv_q [3];
	lavm_pkg::wide_t            acc_q;
	logic                       start_q;
	logic                       second_q;
	logic [2:0]                 k_q;
	logic [1:0]                 row_q;
	logic signed [lavm_pkg::PW-1:0] p_s1;
	logic [2:0]                 pi_s1;
	logic                       pv_s1;

	lavm_pkg::out_beat_t        oq_q [4];
	logic [1:0]                 wp_q;
	logic [1:0]                 rp_q;
	logic [2:0]                 cnt_q;
	logic                       oq_full;
	logic                       oq_push;
	logic                       oq_pop;
	lavm_pkg::out_beat_t        beat;

	lavm_pkg::uvec_t            w [3];
	lavm_pkg::uvec_t            mul_a;
	logic signed [31:0]         mul_b;
	logic [1:0]                 ia;
	logic [1:0]                 ib;
	logic [1:0]                 kd;
	logic                       c_zero;

	// operand order of a cross product: c0 = a1b2 - a2b1, c1 = a2b0 - a0b2, c2 = a0b1 - a1b0
	function automatic logic [1:0] cross_a(input logic [2:0] k);
		case (k)
			3'd0:    cross_a = 2'd1;
			3'd1:    cross_a = 2'd2;
			3'd2:    cross_a = 2'd2;
			3'd3:    cross_a = 2'd0;
			3'd4:    cross_a = 2'd0;
			3'd5:    cross_a = 2'd1;
			default: cross_a = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] cross_b(input logic [2:0] k);
		case (k)
			3'd0:    cross_b = 2'd2;
			3'd1:    cross_b = 2'd1;
			3'd2:    cross_b = 2'd0;
			3'd3:    cross_b = 2'd2;
			3'd4:    cross_b = 2'd1;
			3'd5:    cross_b = 2'd0;
			default: cross_b = 2'd0;
		endcase
	endfunction

	// round half away from zero to Q.F and saturate to 32 bits
	function automatic logic [31:0] round_sat(input lavm_pkg::wide_t s);
		logic [63:0] m;
		logic [63:0] mr;
		m  = s[63] ? 64'(-s) : 64'(s);
		mr = (m + (64'(1) << (lavm_pkg::FRAC_BITS - 1))) >> lavm_pkg::FRAC_BITS;
		if (s[63])
			round_sat = (mr > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mr[31:0];
		else
			round_sat = (mr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mr[31:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (row_q)
				2'd0:    w[i] = r_q[i];
				2'd1:    w[i] = u_q[i];
				default: w[i] = -f_q[i];
			endcase
		end
		ia = cross_a(k_q);
		ib = cross_b(k_q);
		kd = (k_q[1:0] == 2'd3) ? 2'd0 : k_q[1:0];
		if (state_q == B_CROSS) begin
			mul_a = second_q ? r_q[ia] : f_q[ia];
			mul_b = second_q ? 32'(f_q[ib]) : up_q[ib];
		end else begin
			mul_a = w[kd];
			mul_b = cam_q[kd];
		end
		c_zero = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
	end

	// row beat for the queue
	always_comb begin
		beat = '0;
		case (state_q)
			B_ROW: begin
				beat.row_index = row_q;
				beat.elem0     = 32'(w[0]);
				beat.elem1     = 32'(w[1]);
				beat.elem2     = 32'(w[2]);
				beat.elem3     = round_sat(acc_q);
			end
			B_LAST: begin
				beat.row_index = 2'd3;
				beat.elem3     = lavm_pkg::ONE_FX;
				beat.last_row  = 1'b1;
			end
			B_ID: begin
				beat.row_index  = row_q;
				beat.elem0      = (row_q == 2'd0) ? lavm_pkg::ONE_FX : 32'd0;
				beat.elem1      = (row_q == 2'd1) ? lavm_pkg::ONE_FX : 32'd0;
				beat.elem2      = (row_q == 2'd2) ? lavm_pkg::ONE_FX : 32'd0;
				beat.elem3      = (row_q == 2'd3) ? lavm_pkg::ONE_FX : 32'd0;
				beat.last_row   = (row_q == 2'd3);
				beat.degenerate = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign norm_start = start_q;
	assign norm_v     = nv_q;
	assign oq_full    = (cnt_q == 3'd4);
	assign oq_push    = (state_q inside {B_ROW, B_LAST, B_ID}) && !oq_full;
	assign empty      = (cnt_q == 3'd0);
	assign oq_pop     = pop && !empty;
	assign row        = oq_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			start_q  <= 1'b0;
			second_q <= 1'b0;
			k_q      <= 3'd0;
			row_q    <= 2'd0;
			pv_s1    <= 1'b0;
			pi_s1    <= 3'd0;
			wp_q     <= 2'd0;
			rp_q     <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			start_q <= 1'b0;
			pv_s1   <= ((state_q == B_CROSS) && (k_q != 3'd6))
				|| ((state_q == B_DOT) && (k_q != 3'd3));
			pi_s1   <= k_q;
			if (oq_push)
				wp_q <= wp_q + 2'd1;
			if (oq_pop)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(oq_push) - 3'(oq_pop);
			case (state_q)
				B_IDLE: begin
					row_q <= 2'd0;
					if (!q_empty) begin
						state_q <= q_data.degenerate ? B_ID : B_NORM_F;
						start_q <= !q_data.degenerate;
					end
				end
				B_NORM_F: begin
					k_q      <= 3'd0;
					second_q <= 1'b0;
					if (norm_done)
						state_q <= B_CROSS;
				end
				B_CROSS: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd6)
						state_q <= B_CHK;
				end
				B_CHK: begin
					row_q <= 2'd0;
					if (!second_q && c_zero) begin
						state_q <= B_ID;
					end else begin
						start_q <= 1'b1;
						state_q <= second_q ? B_NORM_U : B_NORM_R;
					end
				end
				B_NORM_R: begin
					k_q      <= 3'd0;
					second_q <= 1'b1;
					if (norm_done)
						state_q <= B_CROSS;
				end
				B_NORM_U: begin
					k_q   <= 3'd0;
					row_q <= 2'd0;
					if (norm_done)
						state_q <= B_DOT;
				end
				B_DOT: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd3)
						state_q <= B_ROW;
				end
				B_ROW: begin
					if (!oq_full) begin
						k_q <= 3'd0;
						if (row_q == 2'd2) begin
							state_q <= B_LAST;
						end else begin
							row_q   <= row_q + 2'd1;
							state_q <= B_DOT;
						end
					end
				end
				B_LAST: begin
					if (!oq_full)
						state_q <= B_IDLE;
				end
				B_ID: begin
					if (!oq_full) begin
						row_q <= row_q + 2'd1;
						if (row_q == 2'd3)
							state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= mul_a * mul_b;
		if (oq_push)
			oq_q[wp_q] <= beat;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					for (int i = 0; i < 3; i++) begin
						cam_q[i] <= $signed(q_data.cam[i]);
						up_q[i]  <= $signed(q_data.up[i]);
						nv_q[i]  <= 64'($signed(q_data.d[i]));
					end
				end
			end
			B_NORM_F: begin
				if (norm_done)
					f_q <= norm_o;
			end
			B_NORM_R: begin
				if (norm_done)
					r_q <= norm_o;
			end
			B_NORM_U: begin
				if (norm_done)
					u_q <= norm_o;
			end
			B_CROSS: begin
				if (pv_s1)
					c_q[pi_s1[2:1]] <= pi_s1[0] ? c_q[pi_s1[2:1]] - 64'(p_s1) : 64'(p_s1);
			end
			B_CHK: begin
				nv_q <= c_q;
			end
			B_DOT: begin
				// accumulate the negated dot product directly
				if (pv_s1)
					acc_q <= ((pi_s1[1:0] == 2'd0) ? 64'sd0 : acc_q) - 64'(p_s1);
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/look_at_view_matrix_core.sv */
// top level of the look-at view matrix core
//
// input channel: one beat holds camera position, target point and up hint,
//   signed fixed point with lavm_pkg::FRAC_BITS fraction bits; it is taken
//   on a clock edge with push high and full low
// result channel: four beats per input beat, rows 0 to 3 of the view
//   matrix in order; the oldest row sits on row while empty is low and
//   leaves on a clock edge with pop high
// the front end takes a beat in any cycle while its two-entry queue has
//   room, so a new camera beat is taken while the back end still works
// the back end finishes one camera beat before it takes the next and
//   runs three vector normalizations one after the other, each with a
//   bit-serial square root and three restoring divides in the one
//   shared normalizer
// a beat with position equal to target gives identity rows without any
//   normalization, and one with up parallel to the view gives them
//   after the first normalization and its cross product
// a stalled receiver fills the four-row result queue; the back end then
//   waits and the input queue fills in turn, raising full
// reset clears both queues and returns the sequencers to idle
module look_at_view_matrix_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  lavm_pkg::in_beat_t   camera,
	output logic                 empty,
	input  logic                 pop,
	output lavm_pkg::out_beat_t  row
);

	// classified items between front and back
	logic            q_empty;
	logic            q_pop;
	lavm_pkg::fq_t   q_data;

	// shared normalizer
	logic            norm_start;
	logic            norm_done;
	lavm_pkg::wide_t norm_v [3];
	lavm_pkg::uvec_t norm_o [3];

	lavm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.camera  (camera),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	lavm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.v      (norm_v),
		.done   (norm_done),
		.o      (norm_o)
	);

	// sequencer: normalize f, cross with up, normalize r, cross, normalize u,
	// then three dot products and the constant last row; degenerate views give identity rows
	lavm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.norm_start (norm_start),
		.norm_v     (norm_v),
		.norm_done  (norm_done),
		.norm_o     (norm_o),
		.empty      (empty),
		.pop        (pop),
		.row        (row)
	);

endmodule
